// File: src/gpdr_pkg.sv
// ----------------------------------------------------------------------------
// gpdr_pkg
// shared types, codes and pass tables for the palette deinterlace renderer
// ----------------------------------------------------------------------------
package gpdr_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned IDX_BITS      = 8;
  localparam int unsigned RGB_BITS      = 24;
  localparam int unsigned CFG_DW        = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    ACT_PAL_WRITE = 1'b0,
    ACT_PIXEL     = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    TMODE_NONE = 2'd0,
    TMODE_BG   = 2'd1,
    TMODE_SKIP = 2'd2,
    TMODE_ALT  = 2'd3
  } tmode_e;

  typedef enum logic [2:0] {
    CFG_FRAME_LEFT   = 3'd0,
    CFG_FRAME_TOP    = 3'd1,
    CFG_FRAME_WIDTH  = 3'd2,
    CFG_FRAME_HEIGHT = 3'd3,
    CFG_INTERLACED   = 3'd4,
    CFG_TMODE        = 3'd5,
    CFG_TRANS_INDEX  = 3'd6,
    CFG_BG_INDEX     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                action;
    logic [IDX_BITS-1:0] index;
    logic [RGB_BITS-1:0] rgb_value;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           argb_color;
    logic                  write_pixel;
    logic                  frame_end;
  } out_t;

  // palette port requests from the render control
  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [RGB_BITS-1:0] wr_data;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
  } pal_req_t;

  // first row of each interlace pass
  function automatic logic [3:0] pass_start(input logic [1:0] pass);
    logic [3:0] r;
    unique case (pass)
      2'd0:    r = 4'd0;
      2'd1:    r = 4'd4;
      2'd2:    r = 4'd2;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  // row step within each interlace pass
  function automatic logic [3:0] pass_step(input logic [1:0] pass);
    logic [3:0] r;
    unique case (pass)
      2'd0:    r = 4'd8;
      2'd1:    r = 4'd8;
      2'd2:    r = 4'd4;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

endpackage

// File: src/gif_palette_deinterlace_render.sv
// ----------------------------------------------------------------------------
// gif_palette_deinterlace_render
// maps streamed gif pixel indices to screen position and opaque argb colour
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | carries
//  --------+-------------------------------------------+-----+------------------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in | register write
//  in      | in_valid_i  in_ready_o  in_data_i         | in  | palette write/pixel
//  out     | out_valid_o out_ready_i out_data_o        | out | one result per pixel
//
//  one input transfer per cycle while in_ready_o is high; a pixel result is
//  registered in the palette read register, then in the output register
//  palette writes give no result and pass straight into the memory
//  the post-read stage and the output register form a two-deep buffer, so a
//  pixel is still taken while a finished result waits on out_ready_i
//  reset clears counters and valid flags, sets config to defaults with width
//  and height 1; palette content is undefined until written, no clearing pass
//  cfg_ready_o is always high; the user, not the block, must ensure config is written only while idle
// ----------------------------------------------------------------------------
module gif_palette_deinterlace_render
  import gpdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  // config registers
  logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;
  logic                  ilace_q;
  logic [1:0]            tmode_q;
  logic [IDX_BITS-1:0]   tindex_q, bgindex_q;

  // frame walk state
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [COORD_BITS-1:0] rows_q, rows_d;
  logic [1:0]            pass_q, pass_d;

  // post-read stage
  logic                  s1_valid_q;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                  s1_write_q, s1_end_q;

  // output register
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  in_xfer, pix_xfer, s1_move;
  logic                  key_hit, use_bg, skip;
  logic [COORD_BITS:0]   wlim, hlim, next_col, ro;
  logic [COORD_BITS-1:0] rows_inc;
  logic                  row_end, frame_done;
  logic [1:0]            p;
  pal_req_t              pal_req;
  logic [RGB_BITS-1:0]   pal_data;

  // ---------------------------------------------------------------- handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pix_xfer   = in_xfer && (in_data_i.action == ACT_PIXEL);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      top_q     <= '0;
      width_q   <= COORD_BITS'(1);
      height_q  <= COORD_BITS'(1);
      ilace_q   <= 1'b0;
      tmode_q   <= TMODE_NONE;
      tindex_q  <= '0;
      bgindex_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_LEFT:   left_q    <= cfg_data_i;
        CFG_FRAME_TOP:    top_q     <= cfg_data_i;
        CFG_FRAME_WIDTH:  width_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q  <= cfg_data_i;
        CFG_INTERLACED:   ilace_q   <= cfg_data_i[0];
        CFG_TMODE:        tmode_q   <= cfg_data_i[1:0];
        CFG_TRANS_INDEX:  tindex_q  <= cfg_data_i[IDX_BITS-1:0];
        CFG_BG_INDEX:     bgindex_q <= cfg_data_i[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- transparency
  assign key_hit = (tmode_q != TMODE_NONE) && (in_data_i.index == tindex_q);
  assign use_bg  = key_hit && (tmode_q == TMODE_BG);
  assign skip    = key_hit && (tmode_q != TMODE_BG);

  // ---------------------------------------------------------------- frame walk
  // zero width or height counts as the full 16-bit range
  assign wlim     = {width_q == '0, width_q};
  assign hlim     = {height_q == '0, height_q};
  assign next_col = {1'b0, col_q} + 1'b1;
  assign row_end  = (next_col >= wlim);
  assign rows_inc = rows_q + 1'b1;
  assign frame_done = ({1'b0, rows_inc} >= hlim) || (rows_inc == '0);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    rows_d = rows_q;
    pass_d = pass_q;
    p      = pass_q;
    ro     = {1'b0, row_q} + (COORD_BITS+1)'(pass_step(pass_q));
    // skip passes whose first row lies below the frame
    for (int k = 0; k < 3; k++) begin
      if (ro >= hlim && p != 2'd3) begin
        p  = p + 1'b1;
        ro = (COORD_BITS+1)'(pass_start(p));
      end
    end
    if (pix_xfer) begin
      if (!row_end) begin
        col_d = next_col[COORD_BITS-1:0];
      end else begin
        col_d = '0;
        if (frame_done) begin
          rows_d = '0;
          row_d  = '0;
          pass_d = 2'd0;
        end else if (ilace_q) begin
          rows_d = rows_inc;
          row_d  = ro[COORD_BITS-1:0];
          pass_d = p;
        end else begin
          rows_d = rows_inc;
          row_d  = row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rows_q <= '0;
      pass_q <= 2'd0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      rows_q <= rows_d;
      pass_q <= pass_d;
    end
  end

  // ---------------------------------------------------------------- palette
  always_comb begin
    pal_req.wr_en   = in_xfer && (in_data_i.action == ACT_PAL_WRITE);
    pal_req.wr_addr = in_data_i.index;
    pal_req.wr_data = in_data_i.rgb_value;
    pal_req.rd_en   = pix_xfer;
    pal_req.rd_addr = use_bg ? bgindex_q : in_data_i.index;
  end

  gpdr_palette u_palette (
    .clk_i     (clk_i),
    .req_i     (pal_req),
    .rd_data_o (pal_data)
  );

  // ---------------------------------------------------------------- post-read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_x_q     <= left_q + col_q;
      s1_y_q     <= top_q + row_q;
      s1_write_q <= !skip;
      s1_end_q   <= row_end && frame_done;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.pixel_x     <= s1_x_q;
      out_q.pixel_y     <= s1_y_q;
      out_q.argb_color  <= s1_write_q ? {ALPHA_OPAQUE, pal_data} : '0;
      out_q.write_pixel <= s1_write_q;
      out_q.frame_end   <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a skipped pixel carries no colour
  a_skip_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_pixel |-> out_data_o.argb_color == '0)
    else $error("skipped pixel with colour");

  // a painted pixel is opaque
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_pixel |-> out_data_o.argb_color[31:24] == ALPHA_OPAQUE)
    else $error("painted pixel not opaque");

  // the walk restarts after the last pixel of a frame
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer && row_end && frame_done |=>
      col_q == '0 && row_q == '0 && rows_q == '0 && pass_q == 2'd0)
    else $error("frame walk not restarted");

  // input stalls only with both result stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free buffer");

  // palette reads never run into the memory when the buffer is full
  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_req.rd_en |-> !s1_valid_q || s1_move)
    else $error("palette read over held data");
`endif

endmodule

// File: src/gpdr_palette.sv
// ----------------------------------------------------------------------------
// gpdr_palette
// palette memory, one write and one registered read port
// ----------------------------------------------------------------------------
module gpdr_palette
  import gpdr_pkg::*;
(
  input  logic                clk_i,
  input  pal_req_t            req_i,
  output logic [RGB_BITS-1:0] rd_data_o
);

  logic [RGB_BITS-1:0] mem_q [PALETTE_DEPTH];
  logic [RGB_BITS-1:0] rd_data_q;
  logic                rd_hit_q;
  logic                wr_in_range;
  logic                rd_in_range;

  assign wr_in_range = ({1'b0, req_i.wr_addr} < (IDX_BITS+1)'(PALETTE_DEPTH));
  assign rd_in_range = ({1'b0, req_i.rd_addr} < (IDX_BITS+1)'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in_range) begin
      mem_q[req_i.wr_addr[PAL_AW-1:0]] <= req_i.wr_data;
    end
  end

  // read data holds until the next read request
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr[PAL_AW-1:0]];
      rd_hit_q  <= rd_in_range;
    end
  end

  // slots beyond the palette read as black
  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule
